// ===== rtl/ausart_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the asynchronous serial port core.
// Depends on nothing; used by rtl/async_usart_core.sv.

package ausart_pkg;

  // Default depth of the receive queue.
  localparam int unsigned FIFO_DEPTH_DEF = 2;

  // Operation codes carried in the mode field of an input word.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BAUD_DIVISOR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESCALE_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_ENABLE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TX_ENABLE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TX_NINE_BIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RX_CONTINUOUS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RX_NINE_BIT   = 3'd6;

  localparam int unsigned CFG_DATA_W = 8;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] tx_data;
    logic       tx_ninth;
    logic       rx_pin;
  } usart_in_t;

  typedef struct packed {
    logic       tx_pin;
    logic       tx_buffer_empty;
    logic       shift_empty;
    logic [7:0] rx_data;
    logic       rx_ready;
    logic       rx_overrun;
    logic [1:0] rx_level;
  } usart_out_t;

endpackage

// ===== rtl/async_usart_core.sv =====
`timescale 1ns / 1ps
// Top level of the asynchronous serial port core: baud generator, transmitter,
// receiver and receive queue. Depends on rtl/ausart_pkg.sv.
//
//   Channel | Direction | Handshake              | Word
//   --------+-----------+------------------------+-------------------------------
//   in_     | input     | in_valid / in_ready    | usart_in_t: tick, write or read
//   out_    | output    | out_valid / out_ready  | usart_out_t: pins and flags
//   cfg_    | input     | cfg_valid / cfg_ready  | register index and 8-bit data
//
// The core takes one input word per clock while the output is not stalled. A word
// is captured in an input register, is worked on by a single layer of logic that
// also updates the port state, and its result lands in the output register. The
// rate holds because the baud counter, the shift registers and the queue pointers
// all update in that layer. Reset is synchronous and active low; it returns every
// control and port state register and flag to its idle value (payload registers
// and queue storage are not reset), and the receive queue needs no clearing pass
// because its fill count marks which entries hold data. A stalled output holds its
// word while the input register keeps the next word; the input side stalls only
// when both are full. Configuration writes are taken whenever the input register is empty.

module async_usart_core #(
  parameter int unsigned FIFO_DEPTH = ausart_pkg::FIFO_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ausart_pkg::usart_in_t                in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ausart_pkg::usart_out_t               out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ausart_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ausart_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Queue pointer and fill count widths follow from the depth.
  localparam int unsigned PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(FIFO_DEPTH + 1);

  // Width of the baud counter and of the rollover period (256 * 64 needs 15 bits).
  localparam int unsigned CNT_W = 14;
  localparam int unsigned PER_W = CNT_W + 1;

  // Transmit frame lengths in bits, including start and stop.
  localparam logic [3:0] TX_BITS_8 = 4'd10;
  localparam logic [3:0] TX_BITS_9 = 4'd11;
  // Receive samples per frame.
  localparam logic [3:0] RX_BITS_8 = 4'd9;
  localparam logic [3:0] RX_BITS_9 = 4'd10;

  // Configuration registers.
  logic [7:0]              baud_div_r;
  logic [1:0]              prescale_r;
  logic                    port_en_r;
  logic                    tx_en_r;
  logic                    tx_nine_r;
  logic                    rx_cont_r;
  logic                    rx_nine_r;

  // Port state.
  logic [CNT_W-1:0]        baud_count_r, baud_count_nxt;
  logic [10:0]             tx_shift_r, tx_shift_nxt;
  logic [3:0]              tx_bits_left_r, tx_bits_left_nxt;
  logic [8:0]              tx_hold_r, tx_hold_nxt;
  logic                    tx_hold_full_r, tx_hold_full_nxt;
  logic                    tx_level_r, tx_level_nxt;
  logic [9:0]              rx_shift_r, rx_shift_nxt;
  logic [3:0]              rx_bits_left_r, rx_bits_left_nxt;
  logic [FILL_W-1:0]       fill_r, fill_nxt;
  logic [PTR_W-1:0]        head_r, head_nxt;
  logic [PTR_W-1:0]        tail_r, tail_nxt;
  logic                    overrun_r, overrun_nxt;

  // Receive queue storage and its registered head read.
  logic [7:0]              rx_mem [FIFO_DEPTH];
  logic [7:0]              head_q_r;

  // Pipeline registers.
  logic                    s1_valid_r, s1_valid_nxt;
  ausart_pkg::usart_in_t   s1_r;
  logic                    out_valid_r, out_valid_nxt;
  ausart_pkg::usart_out_t  out_r, result;

  // Working signals.
  logic                    in_fire, s1_fire, cfg_fire;
  logic [PER_W-1:0]        cnt_inc, period;
  logic [2:0]              psc_shift;
  logic                    rollover;
  logic [9:0]              rx_sample;
  logic                    push_en, mem_we, rd_hit;
  logic [7:0]              push_byte;
  logic                    port_en_nxt, rx_cont_nxt;

  // Builds a transmit frame: low start bit, data LSB first, optional ninth bit,
  // high stop bit. Bit 0 goes out first.
  function automatic logic [10:0] build_frame(input logic [8:0] hold, input logic nine);
    logic [10:0] f;
    if (nine) begin
      f = {1'b1, hold[8], hold[7:0], 1'b0};
    end else begin
      f = {2'b01, hold[7:0], 1'b0};
    end
    return f;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  // Handshakes. A word in the input register moves on whenever the output
  // register is free or being emptied in the same cycle.
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_fire;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = !s1_valid_r;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_fire);
  assign out_valid_nxt = s1_fire || (out_valid_r && !out_ready);

  // Baud generator period: (divisor + 1) shifted by the prescale factor.
  always_comb begin
    if (prescale_r[1]) begin
      psc_shift = 3'd2;
    end else if (prescale_r[0]) begin
      psc_shift = 3'd4;
    end else begin
      psc_shift = 3'd6;
    end
    period   = (PER_W'(baud_div_r) + PER_W'(1)) << psc_shift;
    cnt_inc  = PER_W'(baud_count_r) + PER_W'(1);
    // A period shortened by a divisor change still rolls over on the next tick.
    rollover = (cnt_inc >= period);
  end

  // State update for one configuration write or one input word.
  always_comb begin
    baud_count_nxt   = baud_count_r;
    tx_shift_nxt     = tx_shift_r;
    tx_bits_left_nxt = tx_bits_left_r;
    tx_hold_nxt      = tx_hold_r;
    tx_hold_full_nxt = tx_hold_full_r;
    tx_level_nxt     = tx_level_r;
    rx_shift_nxt     = rx_shift_r;
    rx_bits_left_nxt = rx_bits_left_r;
    fill_nxt         = fill_r;
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    overrun_nxt      = overrun_r;
    push_en          = 1'b0;
    push_byte        = '0;
    rd_hit           = 1'b0;
    rx_sample        = {1'b0, rx_shift_r[9] | s1_r.rx_pin, rx_shift_r[8:1]};
    port_en_nxt      = port_en_r;
    rx_cont_nxt      = rx_cont_r;

    if (cfg_fire) begin
      unique case (cfg_index)
        ausart_pkg::REG_PORT_ENABLE: begin
          port_en_nxt = cfg_data[0];
          if (cfg_data[0] != port_en_r) begin
            baud_count_nxt = '0;
          end
        end
        ausart_pkg::REG_RX_CONTINUOUS: begin
          rx_cont_nxt = cfg_data[0];
        end
        default: begin
        end
      endcase
      // Changes to the port or receive enable re-arm the receiver when both end up set, unless prescale bit 1 is set.
      if (((cfg_index == ausart_pkg::REG_PORT_ENABLE) && (cfg_data[0] != port_en_r)) ||
          ((cfg_index == ausart_pkg::REG_RX_CONTINUOUS) && (cfg_data[0] != rx_cont_r))) begin
        if (port_en_nxt && rx_cont_nxt && !prescale_r[1]) begin
          rx_shift_nxt     = '0;
          rx_bits_left_nxt = rx_nine_r ? RX_BITS_9 : RX_BITS_8;
        end
      end
    end else if (s1_fire) begin
      unique case (s1_r.mode)
        ausart_pkg::MODE_TICK: begin
          if (port_en_r) begin
            baud_count_nxt = rollover ? '0 : cnt_inc[CNT_W-1:0];
            // Transmitter: drive the next frame bit, refill from the holding
            // register once the frame has gone out.
            if (rollover && tx_en_r && (tx_bits_left_r != '0)) begin
              tx_level_nxt     = tx_shift_r[0];
              tx_shift_nxt     = tx_shift_r >> 1;
              tx_bits_left_nxt = tx_bits_left_r - 4'd1;
              if ((tx_bits_left_r == 4'd1) && tx_hold_full_r) begin
                tx_shift_nxt     = build_frame(tx_hold_r, tx_nine_r);
                tx_bits_left_nxt = tx_nine_r ? TX_BITS_9 : TX_BITS_8;
                tx_hold_full_nxt = 1'b0;
              end
            end
            // Receiver: shift in one sample, hand the byte to the queue at the
            // end of the frame and re-arm.
            if (rollover && rx_cont_r && (rx_bits_left_r != '0)) begin
              rx_shift_nxt     = rx_sample;
              rx_bits_left_nxt = rx_bits_left_r - 4'd1;
              if (rx_bits_left_r == 4'd1) begin
                push_en          = 1'b1;
                push_byte        = rx_nine_r ? rx_sample[7:0] : rx_sample[8:1];
                rx_shift_nxt     = '0;
                rx_bits_left_nxt = rx_nine_r ? RX_BITS_9 : RX_BITS_8;
              end
            end
          end
        end
        ausart_pkg::MODE_WRITE: begin
          tx_hold_nxt = {s1_r.tx_ninth, s1_r.tx_data};
          if (tx_bits_left_r == '0) begin
            // Shifter idle: the frame starts at once.
            tx_shift_nxt     = build_frame({s1_r.tx_ninth, s1_r.tx_data}, tx_nine_r);
            tx_bits_left_nxt = tx_nine_r ? TX_BITS_9 : TX_BITS_8;
            tx_hold_full_nxt = 1'b0;
          end else begin
            tx_hold_full_nxt = 1'b1;
          end
        end
        ausart_pkg::MODE_READ: begin
          if (fill_r != '0) begin
            rd_hit   = 1'b1;
            fill_nxt = fill_r - 1'b1;
            head_nxt = ptr_inc(head_r);
          end
        end
        default: begin
        end
      endcase

      // A byte that finds the queue full is dropped and flags an overrun.
      if (push_en) begin
        if (fill_r >= FILL_W'(FIFO_DEPTH)) begin
          overrun_nxt = 1'b1;
        end else begin
          fill_nxt = fill_r + 1'b1;
          tail_nxt = ptr_inc(tail_r);
        end
      end
    end
  end

  assign mem_we = push_en && (fill_r < FILL_W'(FIFO_DEPTH));

  // Result word, taken after the update.
  always_comb begin
    result.tx_pin          = tx_level_nxt;
    result.tx_buffer_empty = !tx_hold_full_nxt;
    result.shift_empty     = (tx_bits_left_nxt == '0);
    result.rx_ready        = (fill_nxt != '0);
    result.rx_overrun      = overrun_nxt;
    result.rx_level        = 2'(fill_nxt);
    if (rd_hit) begin
      result.rx_data = head_q_r;
    end else if (fill_nxt == '0) begin
      result.rx_data = '0;
    end else if (mem_we && (fill_r == '0)) begin
      result.rx_data = push_byte;
    end else begin
      result.rx_data = head_q_r;
    end
  end

  // Queue storage and the head read; a write to the next head slot bypasses.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      rx_mem[tail_r] <= push_byte;
    end
    if (mem_we && (tail_r == head_nxt)) begin
      head_q_r <= push_byte;
    end else begin
      head_q_r <= rx_mem[head_nxt];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= in_data;
    end
    if (s1_fire) begin
      out_r <= result;
    end
  end

  // Control and port state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      baud_div_r     <= '0;
      prescale_r     <= '0;
      port_en_r      <= 1'b0;
      tx_en_r        <= 1'b0;
      tx_nine_r      <= 1'b0;
      rx_cont_r      <= 1'b0;
      rx_nine_r      <= 1'b0;
      baud_count_r   <= '0;
      tx_shift_r     <= '0;
      tx_bits_left_r <= '0;
      tx_hold_r      <= '0;
      tx_hold_full_r <= 1'b0;
      tx_level_r     <= 1'b1;
      rx_shift_r     <= '0;
      rx_bits_left_r <= '0;
      fill_r         <= '0;
      head_r         <= '0;
      tail_r         <= '0;
      overrun_r      <= 1'b0;
    end else begin
      s1_valid_r     <= s1_valid_nxt;
      out_valid_r    <= out_valid_nxt;
      baud_count_r   <= baud_count_nxt;
      tx_shift_r     <= tx_shift_nxt;
      tx_bits_left_r <= tx_bits_left_nxt;
      tx_hold_r      <= tx_hold_nxt;
      tx_hold_full_r <= tx_hold_full_nxt;
      tx_level_r     <= tx_level_nxt;
      rx_shift_r     <= rx_shift_nxt;
      rx_bits_left_r <= rx_bits_left_nxt;
      fill_r         <= fill_nxt;
      head_r         <= head_nxt;
      tail_r         <= tail_nxt;
      overrun_r      <= overrun_nxt;
      port_en_r      <= port_en_nxt;
      rx_cont_r      <= rx_cont_nxt;
      if (cfg_fire) begin
        unique case (cfg_index)
          ausart_pkg::REG_BAUD_DIVISOR:  baud_div_r <= cfg_data;
          ausart_pkg::REG_PRESCALE_MODE: prescale_r <= cfg_data[1:0];
          ausart_pkg::REG_TX_ENABLE:     tx_en_r    <= cfg_data[0];
          ausart_pkg::REG_TX_NINE_BIT:   tx_nine_r  <= cfg_data[0];
          ausart_pkg::REG_RX_NINE_BIT:   rx_nine_r  <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The queue never holds more bytes than it has slots.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(FIFO_DEPTH))
    else $error("receive queue fill count beyond depth");

  // A waiting byte in the holding register implies a frame is still shifting.
  a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tx_hold_full_r |-> (tx_bits_left_r != '0))
    else $error("holding register full while shifter idle");

  // The top bit of the receive shift register is always clear between samples.
  a_rx_top_clear: assert property (@(posedge clk) disable iff (!rst_n)
    rx_shift_r[9] == 1'b0)
    else $error("receive shift register top bit set");

  // Every word that leaves the input register shows up in the output register.
  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("processed word lost before output register");

  // The overrun flag is sticky until reset.
  a_overrun_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    overrun_r |=> overrun_r)
    else $error("overrun flag cleared without reset");
`endif

endmodule
